/* design/eept_pkg.sv */
// eept_pkg: shared types and codes for the exit event pending table
// used by eept_ctrl, eept_dp and exit_event_pending_table; depends on nothing
`default_nettype none

package eept_pkg;

	// process slot space, fixed by the width of proc_slot
	localparam int PROC_W     = 8;
	localparam int PROC_DEPTH = 256;

	// item kinds
	localparam logic [1:0] KIND_QUERY  = 2'd0;
	localparam logic [1:0] KIND_RECORD = 2'd1;
	localparam logic [1:0] KIND_WATCH  = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOPROC  = 2'd1;
	localparam logic [1:0] ST_NOSPACE = 2'd2;

	// input word
	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] endpoint;
		logic [PROC_W-1:0]  proc_slot;
		logic               endpoint_ok;
		logic signed [31:0] ipc_endpoint;
	} req_t;

	// result word
	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] endpoint_out;
		logic               more_pending;
		logic               send_notify;
		logic signed [31:0] notify_target;
	} rsp_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic clr_en;
		logic ptr_inc;
		logic scan_rd;
		logic fin;
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic [1:0] kind;
		logic       ok;
		logic       watched;
		logic       clr_last;
		logic       scan_last;
	} dp_sts_t;

endpackage

`default_nettype wire

/* design/eept_ctrl.sv */
// eept_ctrl: sequencer for the exit event pending table
// steps clearing, item dispatch, table scan and finish; uses eept_pkg types
`default_nettype none

module eept_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire eept_pkg::dp_sts_t sts,
	output eept_pkg::dp_cmd_t      cmd,
	output logic                   busy
);

	localparam logic [2:0] S_CLR   = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_DISP  = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_DRAIN = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       need_scan;

	// queries always scan, records only for a watched valid process
	assign need_scan = (sts.kind == eept_pkg::KIND_QUERY) ||
		((sts.kind == eept_pkg::KIND_RECORD) && sts.ok && sts.watched);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLR:   if (sts.clr_last) state_d = S_IDLE;
			S_IDLE:  if (start) state_d = S_DISP;
			S_DISP:  state_d = need_scan ? S_SCAN : S_DONE;
			S_SCAN:  if (sts.scan_last) state_d = S_DRAIN;
			S_DRAIN: state_d = S_DONE;
			S_DONE:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	// command decode
	always_comb begin
		cmd.load    = (state_q == S_IDLE) && start;
		cmd.clr_en  = (state_q == S_CLR);
		cmd.ptr_inc = (state_q == S_CLR) || (state_q == S_SCAN);
		cmd.scan_rd = (state_q == S_SCAN);
		cmd.fin     = (state_q == S_DONE);
	end

	assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

/* design/eept_dp.sv */
// eept_dp: datapath of the exit event pending table
// entry and watch memories, scan pointer, search flags, result register; uses eept_pkg
`default_nettype none

module eept_dp #(
	parameter int SLOTS = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire eept_pkg::dp_cmd_t cmd,
	input  wire eept_pkg::req_t    req,
	input  wire logic              cfg_we,
	input  wire logic [31:0]       cfg_data,
	output eept_pkg::dp_sts_t      sts,
	output eept_pkg::rsp_t         rsp,
	output logic                   done
);

	localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CLR_N = (SLOTS > eept_pkg::PROC_DEPTH) ? SLOTS : eept_pkg::PROC_DEPTH;
	localparam int CW    = $clog2(CLR_N);

	// entry memory: bit 32 busy, bits 31:0 endpoint
	logic [32:0] ent_mem [SLOTS];
	logic        wat_mem [eept_pkg::PROC_DEPTH];

	logic [CW-1:0]         ptr_q;
	eept_pkg::req_t        item_q;
	logic                  watched_q;
	logic signed [31:0]    empty_q;
	logic [32:0]           ent_s1;
	logic [AW-1:0]         idx_s1;
	logic                  rd_vld_s1;
	logic                  found_q;
	logic                  more_q;
	logic                  present_q;
	logic                  free_q;
	logic [AW-1:0]         found_idx_q;
	logic [AW-1:0]         free_idx_q;
	logic signed [31:0]    found_ep_q;
	eept_pkg::rsp_t        rsp_q;
	logic                  done_q;

	logic                  ent_we;
	logic [AW-1:0]         ent_wa;
	logic [32:0]           ent_wd;
	logic                  wat_we;
	logic [eept_pkg::PROC_W-1:0] wat_wa;
	logic                  in_ent;
	logic                  in_wat;
	logic                  do_ins;
	logic                  rec_go;
	eept_pkg::rsp_t        rsp_d;

	// clear pass range checks, widened so the depth itself fits
	assign in_ent = ({1'b0, ptr_q} < (CW+1)'(SLOTS));
	assign in_wat = ({1'b0, ptr_q} < (CW+1)'(eept_pkg::PROC_DEPTH));

	// record outcome from the scan flags
	assign rec_go = (item_q.kind == eept_pkg::KIND_RECORD) && item_q.endpoint_ok
		&& watched_q;
	assign do_ins = rec_go && !present_q && free_q;

	// memory write select
	always_comb begin
		ent_we = 1'b0;
		ent_wa = ptr_q[AW-1:0];
		ent_wd = '0;
		wat_we = 1'b0;
		wat_wa = ptr_q[eept_pkg::PROC_W-1:0];
		if (cmd.clr_en) begin
			ent_we = in_ent;
			wat_we = in_wat;
		end else if (cmd.fin) begin
			if ((item_q.kind == eept_pkg::KIND_QUERY) && found_q) begin
				ent_we = 1'b1;
				ent_wa = found_idx_q;
			end else if (do_ins) begin
				ent_we = 1'b1;
				ent_wa = free_idx_q;
				ent_wd = {1'b1, item_q.endpoint};
			end
			if ((item_q.kind == eept_pkg::KIND_WATCH) && item_q.endpoint_ok) begin
				wat_we = 1'b1;
				wat_wa = item_q.proc_slot;
			end
		end
	end

	// memories, registered reads
	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_mem[ent_wa] <= ent_wd;
		end
		if (cmd.scan_rd) begin
			ent_s1 <= ent_mem[ptr_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (wat_we) begin
			wat_mem[wat_wa] <= 1'b1 & ~cmd.clr_en;
		end
		if (cmd.load) begin
			watched_q <= wat_mem[req.proc_slot];
		end
	end

	// item capture and scan index
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= req;
		end
		if (cmd.scan_rd) begin
			idx_s1 <= ptr_q[AW-1:0];
		end
	end

	// pointer, read valid and config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q     <= '0;
			rd_vld_s1 <= 1'b0;
			empty_q   <= '0;
		end else begin
			rd_vld_s1 <= cmd.scan_rd;
			if (cmd.load) begin
				ptr_q <= '0;
			end else if (cmd.ptr_inc) begin
				ptr_q <= ptr_q + CW'(1);
			end
			if (cfg_we) begin
				empty_q <= cfg_data;
			end
		end
	end

	// search flags over the scanned entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q   <= 1'b0;
			more_q    <= 1'b0;
			present_q <= 1'b0;
			free_q    <= 1'b0;
		end else if (cmd.load) begin
			found_q   <= 1'b0;
			more_q    <= 1'b0;
			present_q <= 1'b0;
			free_q    <= 1'b0;
		end else if (rd_vld_s1) begin
			if (ent_s1[32]) begin
				if (!found_q) begin
					found_q <= 1'b1;
				end else begin
					more_q <= 1'b1;
				end
				if (ent_s1[31:0] == item_q.endpoint) begin
					present_q <= 1'b1;
				end
			end else if (!free_q) begin
				free_q <= 1'b1;
			end
		end
	end

	// indexes and endpoint of the first hits
	always_ff @(posedge clk) begin
		if (rd_vld_s1 && ent_s1[32] && !found_q) begin
			found_idx_q <= idx_s1;
			found_ep_q  <= ent_s1[31:0];
		end
		if (rd_vld_s1 && !ent_s1[32] && !free_q) begin
			free_idx_q <= idx_s1;
		end
	end

	// result word
	always_comb begin
		rsp_d = '0;
		case (item_q.kind)
			eept_pkg::KIND_QUERY: begin
				rsp_d.endpoint_out = found_q ? found_ep_q : empty_q;
				rsp_d.more_pending = more_q;
			end
			eept_pkg::KIND_RECORD: begin
				if (!item_q.endpoint_ok) begin
					rsp_d.status = eept_pkg::ST_NOPROC;
				end else if (watched_q) begin
					if (!present_q && !free_q) begin
						rsp_d.status = eept_pkg::ST_NOSPACE;
					end else if ((item_q.ipc_endpoint != 32'sd0) &&
						(item_q.ipc_endpoint != item_q.endpoint)) begin
						rsp_d.send_notify   = 1'b1;
						rsp_d.notify_target = item_q.ipc_endpoint;
					end
				end
			end
			eept_pkg::KIND_WATCH: begin
				if (!item_q.endpoint_ok) begin
					rsp_d.status = eept_pkg::ST_NOPROC;
				end
			end
			default: rsp_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.fin;
		end
	end

	// status toward the controller
	always_comb begin
		sts.kind      = item_q.kind;
		sts.ok        = item_q.endpoint_ok;
		sts.watched   = watched_q;
		sts.clr_last  = (ptr_q == CW'(CLR_N - 1));
		sts.scan_last = (ptr_q == CW'(SLOTS - 1));
	end

	assign rsp  = rsp_q;
	assign done = done_q;

endmodule

`default_nettype wire

/* design/exit_event_pending_table.sv */
// exit_event_pending_table: top level of the exit event pending table
// joins eept_ctrl and eept_dp; uses eept_pkg types and codes
//
// channel   signals                       handshake
// -------   ---------------------------   --------------------------------
// request   start, busy, req              word taken when start & !busy
// result    done, rsp                     one word per request, done 1 cycle
// config    cfg_valid, cfg_ready, cfg_data  written when cfg_valid & cfg_ready
//
// a query or a record of a watched process walks the entry memory one entry
// per cycle through its single read port; other items skip the scan.
// after reset the memories are cleared while busy is high.
// the receiver cannot stall; done marks each result for one cycle.
`default_nettype none

module exit_event_pending_table #(
	parameter int SLOTS = 256
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire eept_pkg::req_t req,
	output logic                done,
	output eept_pkg::rsp_t      rsp,
	input  wire logic           cfg_valid,
	output logic                cfg_ready,
	input  wire logic [31:0]    cfg_data
);

	eept_pkg::dp_cmd_t cmd;
	eept_pkg::dp_sts_t sts;

	// config register always takes writes
	assign cfg_ready = 1'b1;

	eept_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	eept_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req      (req),
		.cfg_we   (cfg_valid & cfg_ready),
		.cfg_data (cfg_data),
		.sts      (sts),
		.rsp      (rsp),
		.done     (done)
	);

	// an accepted word makes the block busy
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accepted word");

	// a result lasts one cycle and is shown while idle
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy ##1 !done)
		else $error("result strobe longer than one cycle");

	// a notify always carries a target
	a_notify_target: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.send_notify |-> rsp.notify_target != 32'sd0)
		else $error("notify without target");

	// a full table raises no notify
	a_nospace_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		done && (rsp.status == eept_pkg::ST_NOSPACE) |-> !rsp.send_notify)
		else $error("notify raised on full table");

endmodule

`default_nettype wire
